// ----- design/mm4_pkg.sv -----
// Shared field widths and command codes of the 4x4 matrix multiply-accumulate block.
`timescale 1ns / 1ps

package mm4_pkg;

  localparam int unsigned ModeBits  = 2;
  localparam int unsigned IndexBits = 4;
  localparam int unsigned ValueBits = 32;

  typedef logic [ModeBits-1:0] mode_t;

  localparam mode_t MODE_WR_LEFT  = 2'd0;
  localparam mode_t MODE_WR_RIGHT = 2'd1;
  localparam mode_t MODE_MULTIPLY = 2'd2;

endpackage

// ----- design/matrix4x4_multiply_accumulate.sv -----
// Top level of the matrix multiply-accumulate block: storage, sequencer and shared multiplier.
`timescale 1ns / 1ps

// A write beat (mode 0 or 1) stores one element of the left or right matrix; busy_o stays
// low. A multiply beat (mode 2) raises busy_o and emits the DIM*DIM elements of left times
// right in row-major order, one strobe per element. Each element needs, per term, a read of
// both matrices, two half-width passes through the single shared multiplier and an
// accumulate of each partial product, then an arithmetic shift (truncating) and saturation.
// When keep_product is set, each result row is also written back into the left matrix after
// it is emitted. Results are driven for exactly one cycle and the receiver cannot stall them.
// Both matrices read as zero after reset; no clearing pass is run.
module matrix4x4_multiply_accumulate #(
  parameter int unsigned DIM       = 4,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [mm4_pkg::ModeBits-1:0]          mode_i,
  input  logic [mm4_pkg::IndexBits-1:0]         elem_index_i,
  input  logic signed [mm4_pkg::ValueBits-1:0]  elem_value_i,
  input  logic                                  keep_product_i,
  output logic                                  prod_strobe_o,
  output logic signed [mm4_pkg::ValueBits-1:0]  prod_value_o,
  output logic [mm4_pkg::IndexBits-1:0]         prod_index_o,
  output logic                                  sat_flag_o,
  output logic                                  last_elem_o
);

  localparam int unsigned CELLS  = DIM * DIM;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(DIM);
  localparam int unsigned IW     = (ADDR_W >= 4) ? ADDR_W + 1 : 5;
  localparam int unsigned HB     = (WORD_BITS + 1) / 2;
  localparam int unsigned PW     = WORD_BITS + HB + 1;
  localparam int unsigned ACC_W  = 2 * WORD_BITS + $clog2(DIM) + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MLO  = 3'd2;
  localparam logic [2:0] ST_MHI  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;
  localparam logic [2:0] ST_WB   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [ADDR_W-1:0] cell_q, cell_d;
  logic              keep_q, keep_d;

  logic [WORD_BITS-1:0] left_mem  [CELLS];
  logic [WORD_BITS-1:0] right_mem [CELLS];
  logic [CELLS-1:0]     left_vld_q, right_vld_q;
  logic [WORD_BITS-1:0] row_buf_q [DIM];

  logic signed [WORD_BITS-1:0] a_q;
  logic [WORD_BITS-1:0]        b_q;
  logic signed [PW-1:0]        prod_q, prod_d;
  logic signed [ACC_W-1:0]     acc_q, acc_d, acc_base;
  logic signed [HB:0]          mul_op;

  logic              accept;
  logic [IW-1:0]     idx_w;
  logic              idx_ok;
  logic [WORD_BITS-1:0] wr_value;

  logic              lwr_en, rwr_en;
  logic [ADDR_W-1:0] lwr_addr, rwr_addr, la_addr, rb_addr;
  logic [WORD_BITS-1:0] lwr_data;

  logic signed [ACC_W-1:0] shifted;
  logic                    fits;
  logic [WORD_BITS-1:0]    sat_word;
  logic                    i_last, j_last, k_last;

  logic                    strobe_q;
  logic [mm4_pkg::ValueBits-1:0] pval_q;
  logic [mm4_pkg::IndexBits-1:0] pidx_q;
  logic                    psat_q, plast_q;

  assign busy_o   = (state_q != ST_IDLE);
  assign accept   = start_i && !busy_o;
  assign idx_w    = IW'(elem_index_i);
  assign idx_ok   = (idx_w < IW'(CELLS));
  assign wr_value = WORD_BITS'(elem_value_i);

  assign i_last = (i_q == CNT_W'(DIM - 1));
  assign j_last = (j_q == CNT_W'(DIM - 1));
  assign k_last = (k_q == CNT_W'(DIM - 1));

  assign la_addr = ADDR_W'(i_q) * ADDR_W'(DIM) + ADDR_W'(k_q);
  assign rb_addr = ADDR_W'(k_q) * ADDR_W'(DIM) + ADDR_W'(j_q);

  always_comb begin
    lwr_en   = 1'b0;
    lwr_addr = idx_w[ADDR_W-1:0];
    lwr_data = wr_value;
    rwr_en   = accept && (mode_i == mm4_pkg::MODE_WR_RIGHT) && idx_ok;
    rwr_addr = idx_w[ADDR_W-1:0];
    if (state_q == ST_WB) begin
      lwr_en   = 1'b1;
      lwr_addr = ADDR_W'(i_q) * ADDR_W'(DIM) + ADDR_W'(j_q);
      lwr_data = row_buf_q[j_q];
    end else if (accept && (mode_i == mm4_pkg::MODE_WR_LEFT) && idx_ok) begin
      lwr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lwr_en) begin
      left_mem[lwr_addr] <= lwr_data;
    end
    if (rwr_en) begin
      right_mem[rwr_addr] <= wr_value;
    end
    if (state_q == ST_READ) begin
      a_q <= left_vld_q[la_addr] ? left_mem[la_addr] : '0;
      b_q <= right_vld_q[rb_addr] ? right_mem[rb_addr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_vld_q  <= '0;
      right_vld_q <= '0;
    end else begin
      if (lwr_en) begin
        left_vld_q[lwr_addr] <= 1'b1;
      end
      if (rwr_en) begin
        right_vld_q[rwr_addr] <= 1'b1;
      end
    end
  end

  // The right operand is split into an unsigned low half and a signed high half.
  always_comb begin
    if (state_q == ST_MLO) begin
      mul_op = signed'({1'b0, b_q[HB-1:0]});
    end else begin
      mul_op = (HB + 1)'(signed'(b_q[WORD_BITS-1:HB]));
    end
  end

  assign acc_base = (k_q == '0) ? '0 : acc_q;

  assign shifted  = acc_q >>> FRAC_BITS;
  assign fits     = (&shifted[ACC_W-1:WORD_BITS-1]) || !(|shifted[ACC_W-1:WORD_BITS-1]);
  assign sat_word = fits ? shifted[WORD_BITS-1:0] :
                    (acc_q[ACC_W-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                    : {1'b0, {(WORD_BITS-1){1'b1}}});

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    cell_d  = cell_q;
    keep_d  = keep_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (mode_i == mm4_pkg::MODE_MULTIPLY)) begin
          state_d = ST_READ;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          cell_d  = '0;
          keep_d  = keep_product_i;
        end
      end
      ST_READ: begin
        state_d = ST_MLO;
      end
      ST_MLO: begin
        prod_d  = a_q * mul_op;
        state_d = ST_MHI;
      end
      ST_MHI: begin
        acc_d   = acc_base + ACC_W'(prod_q);
        prod_d  = a_q * mul_op;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d = acc_q + (ACC_W'(prod_q) <<< HB);
        if (k_last) begin
          state_d = ST_EMIT;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_EMIT: begin
        k_d    = '0;
        cell_d = cell_q + 1'b1;
        if (!j_last) begin
          j_d     = j_q + 1'b1;
          state_d = ST_READ;
        end else begin
          j_d = '0;
          if (keep_q) begin
            state_d = ST_WB;
          end else if (i_last) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_READ;
          end
        end
      end
      ST_WB: begin
        if (!j_last) begin
          j_d = j_q + 1'b1;
        end else begin
          j_d = '0;
          if (i_last) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      cell_q   <= '0;
      keep_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      cell_q   <= cell_d;
      keep_q   <= keep_d;
      strobe_q <= (state_q == ST_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (state_q == ST_EMIT) begin
      row_buf_q[j_q] <= sat_word;
      pval_q         <= mm4_pkg::ValueBits'(sat_word);
      pidx_q         <= mm4_pkg::IndexBits'(cell_q);
      psat_q         <= !fits;
      plast_q        <= (cell_q == ADDR_W'(CELLS - 1));
    end
  end

  assign prod_strobe_o = strobe_q;
  assign prod_value_o  = signed'(pval_q);
  assign prod_index_o  = pidx_q;
  assign sat_flag_o    = psat_q;
  assign last_elem_o   = plast_q;

  a_strobe_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_strobe_o |-> $past(state_q == ST_EMIT))
    else $error("result strobe without an emit cycle");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prod_strobe_o && last_elem_o) |-> (state_q == ST_IDLE || state_q == ST_WB))
    else $error("multiply continues after its last element");

  a_multiply_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i == mm4_pkg::MODE_MULTIPLY) |=> busy_o)
    else $error("multiply beat did not start the sequencer");

  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i != mm4_pkg::MODE_MULTIPLY) |=> !busy_o && !prod_strobe_o)
    else $error("element write started a run");

endmodule

// ----- dv/tb_matrix4x4_multiply_accumulate.sv -----
// Self-checking testbench for the 4x4 fixed-point matrix multiply-accumulate block.
`timescale 1ns / 1ps

module tb_matrix4x4_multiply_accumulate;

  localparam int unsigned Dim         = 4;
  localparam int unsigned Cells       = Dim * Dim;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned RandomItems = 300;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned MaxReports  = 10;

  localparam mm4_pkg::mode_t MODE_UNUSED = 2'd3;

  localparam logic signed [65:0] WordMax = 66'sd2147483647;
  localparam logic signed [65:0] WordMin = -66'sd2147483648;

  typedef enum int unsigned {
    VAL_SMALL,
    VAL_MEDIUM,
    VAL_FULL,
    VAL_EXTREME
  } value_class_e;

  typedef struct packed {
    logic signed [mm4_pkg::ValueBits-1:0] value;
    logic [mm4_pkg::IndexBits-1:0]        index;
    logic                                 sat;
    logic                                 last;
  } product_t;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 start_i;
  logic                                 busy_o;
  logic [mm4_pkg::ModeBits-1:0]         mode_i;
  logic [mm4_pkg::IndexBits-1:0]        elem_index_i;
  logic signed [mm4_pkg::ValueBits-1:0] elem_value_i;
  logic                                 keep_product_i;
  logic                                 prod_strobe_o;
  logic signed [mm4_pkg::ValueBits-1:0] prod_value_o;
  logic [mm4_pkg::IndexBits-1:0]        prod_index_o;
  logic                                 sat_flag_o;
  logic                                 last_elem_o;

  logic signed [mm4_pkg::ValueBits-1:0] model_left[Cells];
  logic signed [mm4_pkg::ValueBits-1:0] model_right[Cells];
  product_t                             pending_products[$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned beats_sent;
  int unsigned multiplies_sent;
  int unsigned products_checked;
  int unsigned saturated_seen;
  bit          idle_enabled;

  matrix4x4_multiply_accumulate u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .elem_index_i   (elem_index_i),
    .elem_value_i   (elem_value_i),
    .keep_product_i (keep_product_i),
    .prod_strobe_o  (prod_strobe_o),
    .prod_value_o   (prod_value_o),
    .prod_index_o   (prod_index_o),
    .sat_flag_o     (sat_flag_o),
    .last_elem_o    (last_elem_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d products outstanding", cycle_count,
               pending_products.size());
      $display("tb_matrix4x4_multiply_accumulate failed");
      $finish;
    end
  end

  task automatic predict_product(input logic keep);
    int                 i;
    int                 j;
    int                 k;
    logic signed [65:0] acc;
    logic signed [65:0] a_ext;
    logic signed [65:0] b_ext;
    logic signed [65:0] scaled;
    logic signed [mm4_pkg::ValueBits-1:0] row_words[Dim];
    product_t           p;
    for (i = 0; i < Dim; i++) begin
      for (j = 0; j < Dim; j++) begin
        acc = '0;
        for (k = 0; k < Dim; k++) begin
          a_ext = 66'(model_left[i*Dim+k]);
          b_ext = 66'(model_right[k*Dim+j]);
          acc   = acc + a_ext * b_ext;
        end
        scaled = acc >>> FracBits;
        if (scaled > WordMax) begin
          p.value = WordMax[mm4_pkg::ValueBits-1:0];
          p.sat   = 1'b1;
        end else if (scaled < WordMin) begin
          p.value = WordMin[mm4_pkg::ValueBits-1:0];
          p.sat   = 1'b1;
        end else begin
          p.value = scaled[mm4_pkg::ValueBits-1:0];
          p.sat   = 1'b0;
        end
        p.index     = mm4_pkg::IndexBits'(i * Dim + j);
        p.last      = (i * Dim + j == Cells - 1);
        row_words[j] = p.value;
        pending_products.push_back(p);
      end
      if (keep) begin
        for (j = 0; j < Dim; j++) begin
          model_left[i*Dim+j] = row_words[j];
        end
      end
    end
  endtask

  // Inputs change on the falling edge; a beat is taken at the first rising edge with busy low.
  task automatic send_beat(input mm4_pkg::mode_t mode,
                           input logic [mm4_pkg::IndexBits-1:0] index,
                           input logic [mm4_pkg::ValueBits-1:0] value, input logic keep);
    @(negedge clk_i);
    start_i        = 1'b1;
    mode_i         = mode;
    elem_index_i   = index;
    elem_value_i   = value;
    keep_product_i = keep;
    do @(posedge clk_i); while (busy_o);
    case (mode)
      mm4_pkg::MODE_WR_LEFT: begin
        model_left[index] = value;
      end
      mm4_pkg::MODE_WR_RIGHT: begin
        model_right[index] = value;
      end
      mm4_pkg::MODE_MULTIPLY: begin
        predict_product(keep);
        multiplies_sent++;
      end
      default: begin
      end
    endcase
    if (mode != MODE_UNUSED) begin
      beats_sent++;
    end
  endtask

  task automatic idle_cycles(input int unsigned n);
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic maybe_idle();
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      idle_cycles($urandom_range(1, 16));
    end
  endtask

  function automatic logic [mm4_pkg::ValueBits-1:0] random_value(input value_class_e cls);
    logic [mm4_pkg::ValueBits-1:0] v;
    case (cls)
      VAL_SMALL:  v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      VAL_MEDIUM: v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      VAL_FULL:   v = $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h7fff_ffff;
          1:       v = 32'h8000_0000;
          2:       v = 32'hffff_ffff;
          3:       v = 32'h0001_0000;
          default: v = 32'h0000_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic mm4_pkg::mode_t random_write_mode();
    return ($urandom_range(0, 1) == 0) ? mm4_pkg::MODE_WR_LEFT : mm4_pkg::MODE_WR_RIGHT;
  endfunction

  function automatic logic [mm4_pkg::IndexBits-1:0] random_index();
    return mm4_pkg::IndexBits'($urandom);
  endfunction

  function automatic logic random_bit();
    return 1'($urandom);
  endfunction

  always @(posedge clk_i) begin
    product_t want;
    if (rst_ni && prod_strobe_o) begin
      if (pending_products.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("Unexpected product beat: value %h index %0d sat %b last %b",
                   prod_value_o, prod_index_o, sat_flag_o, last_elem_o);
        end
      end else begin
        want = pending_products.pop_front();
        products_checked++;
        if (sat_flag_o) begin
          saturated_seen++;
        end
        if (prod_value_o !== want.value || prod_index_o !== want.index ||
            sat_flag_o !== want.sat || last_elem_o !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("Product mismatch: expected value %h index %0d sat %b last %b",
                     want.value, want.index, want.sat, want.last);
            $display("                  actual   value %h index %0d sat %b last %b",
                     prod_value_o, prod_index_o, sat_flag_o, last_elem_o);
          end
        end
      end
    end
  end

  task automatic test_after_reset();
    send_beat(mm4_pkg::MODE_MULTIPLY, random_index(), $urandom, 1'b1);
    send_beat(MODE_UNUSED, 4'd0, 32'h7fff_ffff, 1'b1);
    send_beat(mm4_pkg::MODE_MULTIPLY, random_index(), $urandom, 1'b0);
  endtask

  task automatic test_saturation_and_truncation();
    send_beat(mm4_pkg::MODE_WR_LEFT, 4'd0, 32'h7fff_ffff, 1'b1);
    send_beat(mm4_pkg::MODE_WR_LEFT, 4'd1, 32'h7fff_ffff, 1'b0);
    send_beat(mm4_pkg::MODE_WR_RIGHT, 4'd0, 32'h7fff_ffff, 1'b1);
    send_beat(mm4_pkg::MODE_WR_RIGHT, 4'd4, 32'h7fff_ffff, 1'b0);
    send_beat(mm4_pkg::MODE_WR_LEFT, 4'd4, 32'h8000_0000, 1'b0);
    send_beat(mm4_pkg::MODE_WR_RIGHT, 4'd1, 32'h7fff_ffff, 1'b0);
    send_beat(mm4_pkg::MODE_WR_LEFT, 4'd10, 32'h0001_0000, 1'b0);
    send_beat(mm4_pkg::MODE_WR_RIGHT, 4'd10, 32'h7fff_ffff, 1'b0);
    send_beat(mm4_pkg::MODE_WR_LEFT, 4'd15, 32'h0001_0000, 1'b0);
    send_beat(mm4_pkg::MODE_WR_RIGHT, 4'd15, 32'h8000_0000, 1'b0);
    send_beat(mm4_pkg::MODE_WR_LEFT, 4'd14, 32'hffff_ffff, 1'b0);
    send_beat(mm4_pkg::MODE_WR_RIGHT, 4'd14, 32'h0000_0001, 1'b1);
    send_beat(mm4_pkg::MODE_MULTIPLY, 4'd15, 32'h8000_0000, 1'b0);
  endtask

  task automatic test_in_place_multiply();
    send_beat(mm4_pkg::MODE_MULTIPLY, 4'd0, 32'hffff_ffff, 1'b1);
    send_beat(mm4_pkg::MODE_MULTIPLY, 4'd7, 32'h1234_5678, 1'b1);
    send_beat(mm4_pkg::MODE_MULTIPLY, random_index(), $urandom, 1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned target);
    int unsigned  n;
    int unsigned  c;
    value_class_e cls;
    bit           burst_idle;
    while (beats_sent < target) begin
      burst_idle   = ($urandom_range(0, 2) != 0);
      idle_enabled = burst_idle && (beats_sent < target * 85 / 100);
      cls          = value_class_e'($urandom_range(0, 3));
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 4);
        for (int unsigned b = 0; b < n; b++) begin
          send_beat(mm4_pkg::mode_t'($urandom_range(0, 3)), random_index(), $urandom,
                    random_bit());
          maybe_idle();
        end
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          for (c = 0; c < 2 * Cells; c++) begin
            send_beat((c < Cells) ? mm4_pkg::MODE_WR_LEFT : mm4_pkg::MODE_WR_RIGHT,
                      mm4_pkg::IndexBits'(c % Cells), random_value(cls), random_bit());
            maybe_idle();
          end
        end else begin
          n = $urandom_range(1, 16);
          for (c = 0; c < n; c++) begin
            send_beat(random_write_mode(), random_index(), random_value(cls), random_bit());
            maybe_idle();
          end
        end
        send_beat(mm4_pkg::MODE_MULTIPLY, random_index(), $urandom, random_bit());
        maybe_idle();
      end
    end
    idle_enabled = 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    mode_i         = mm4_pkg::MODE_WR_LEFT;
    elem_index_i   = '0;
    elem_value_i   = '0;
    keep_product_i = 1'b0;
    idle_enabled   = 1'b0;
    for (int c = 0; c < Cells; c++) begin
      model_left[c]  = '0;
      model_right[c] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_after_reset();
    test_saturation_and_truncation();
    test_in_place_multiply();
    test_random_traffic(beats_sent + RandomItems);

    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_products.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d beats including %0d multiplies; checked %0d product elements.",
             beats_sent, multiplies_sent, products_checked);
    $display("Saturated elements seen: %0d; mismatches: %0d.", saturated_seen, mismatch_count);
    if (mismatch_count == 0 && pending_products.size() == 0) begin
      $display("tb_matrix4x4_multiply_accumulate passed");
    end else begin
      $display("tb_matrix4x4_multiply_accumulate failed");
    end
    $finish;
  end

endmodule
